// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the port-level checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ----- src/vwlc_pkg.sv -----
// ----------------------------------------------------------------------------
// vwlc_pkg
// types and constants for the vertex window load cost block
// ----------------------------------------------------------------------------
`default_nettype none

package vwlc_pkg;

   localparam int CORNER_W = 10;
   localparam int FILL_W   = 8;
   localparam int COST_W   = 32;
   localparam int NEW_W    = 2;
   localparam int NEED_W   = 2;

   localparam logic [FILL_W-1:0] CAPACITY_RESET = 8'd64;

   typedef struct packed {
      logic                start_mesh;
      logic [CORNER_W-1:0] corner_a;
      logic [CORNER_W-1:0] corner_b;
      logic [CORNER_W-1:0] corner_c;
   } req_type;

   typedef struct packed {
      logic              flushed;
      logic [NEW_W-1:0]  new_vertices;
      logic [FILL_W-1:0] window_fill;
      logic [COST_W-1:0] total_cost;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/vwlc_input_stage.sv -----
// ----------------------------------------------------------------------------
// vwlc_input_stage
// request register and corner to slot reduction
// ----------------------------------------------------------------------------
`default_nettype none

module vwlc_input_stage #(
   parameter int VERTEX_LIMIT = 1024,
   parameter int SLOT_W       = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire vwlc_pkg::req_type           req_payload,
   input  wire logic                        advance,
   output      logic                        item_valid,
   output      logic                        start_mesh,
   output      logic [2:0][SLOT_W-1:0]      slot
);

   localparam int CW = vwlc_pkg::CORNER_W;

   logic              valid_ff;
   logic              valid_in;
   logic              accept;
   vwlc_pkg::req_type payload_ff;
   logic [2:0][CW-1:0] corner_req;
   logic [2:0][CW-1:0] corner_ff;

   assign accept     = req_valid & ~req_stall;
   assign req_stall  = valid_ff & ~advance;
   assign valid_in   = accept | (valid_ff & ~advance);
   assign item_valid = valid_ff;
   assign start_mesh = payload_ff.start_mesh;

   assign corner_req[0] = req_payload.corner_a;
   assign corner_req[1] = req_payload.corner_b;
   assign corner_req[2] = req_payload.corner_c;
   assign corner_ff[0]  = payload_ff.corner_a;
   assign corner_ff[1]  = payload_ff.corner_b;
   assign corner_ff[2]  = payload_ff.corner_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         payload_ff <= req_payload;
      end
   end

   generate
      if (VERTEX_LIMIT >= (1 << CW)) begin : g_direct
         always_comb begin
            for (int k = 0; k < 3; k++) begin
               slot[k] = SLOT_W'(corner_ff[k]);
            end
         end
      end else if ((VERTEX_LIMIT & (VERTEX_LIMIT - 1)) == 0) begin : g_mask
         always_comb begin
            for (int k = 0; k < 3; k++) begin
               slot[k] = corner_ff[k][SLOT_W-1:0];
            end
         end
      end else begin : g_recip
         // exact floor division by a reciprocal, remainder after the register
         localparam int SHIFT   = CW + SLOT_W;
         localparam int RECIP_W = CW + 2;
         localparam int PROD_W  = CW + RECIP_W;
         localparam logic [RECIP_W-1:0] RECIP =
            RECIP_W'(((64'd1 << SHIFT) + VERTEX_LIMIT - 1) / VERTEX_LIMIT);
         localparam logic [CW-1:0] LIMIT = CW'(VERTEX_LIMIT);

         logic [2:0][CW-1:0] quot_in;
         logic [2:0][CW-1:0] quot_ff;
         logic [2:0][CW-1:0] rem;

         always_comb begin
            for (int k = 0; k < 3; k++) begin
               quot_in[k] = CW'((PROD_W'(corner_req[k]) * PROD_W'(RECIP)) >> SHIFT);
            end
         end

         always_ff @(posedge clock) begin
            if (accept) begin
               quot_ff <= quot_in;
            end
         end

         always_comb begin
            for (int k = 0; k < 3; k++) begin
               rem[k]  = corner_ff[k] - CW'(quot_ff[k] * LIMIT);
               slot[k] = rem[k][SLOT_W-1:0];
            end
         end
      end
   endgenerate

endmodule

`default_nettype wire

// ----- src/vwlc_window_core.sv -----
// ----------------------------------------------------------------------------
// vwlc_window_core
// membership vector, fill and cost state, per-triangle update
// ----------------------------------------------------------------------------
`default_nettype none

module vwlc_window_core #(
   parameter int VERTEX_LIMIT = 1024,
   parameter int SLOT_W       = 10
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire logic                               start_mesh,
   input  wire logic [2:0][SLOT_W-1:0]             slot,
   input  wire logic                               csr_wr_en,
   input  wire logic [vwlc_pkg::FILL_W-1:0]        csr_wr_data,
   output      vwlc_pkg::rsp_type                  rsp_next
);

   localparam int FW = vwlc_pkg::FILL_W;
   localparam int CW = vwlc_pkg::COST_W;

   logic [VERTEX_LIMIT-1:0] in_window_ff;
   logic [VERTEX_LIMIT-1:0] in_window_in;
   logic [FW-1:0]           fill_ff;
   logic [FW-1:0]           fill_in;
   logic [CW-1:0]           cost_ff;
   logic [CW-1:0]           cost_in;
   logic [FW-1:0]           capacity_ff;

   logic [VERTEX_LIMIT-1:0] win_base;
   logic [VERTEX_LIMIT-1:0] mark;
   logic [FW-1:0]           fill_base;
   logic [CW-1:0]           cost_base;
   logic [2:0]              hit;
   logic [2:0]              miss;
   logic [2:0]              fresh;
   logic [vwlc_pkg::NEED_W-1:0] need;
   logic [vwlc_pkg::NEW_W-1:0]  added;
   logic                    flush;
   logic [CW:0]             cost_sum;

   always_comb begin
      win_base  = start_mesh ? '0 : in_window_ff;
      fill_base = start_mesh ? '0 : fill_ff;
      cost_base = start_mesh ? '0 : cost_ff;

      for (int k = 0; k < 3; k++) begin
         hit[k] = win_base[slot[k]];
      end
      need  = {1'b0, ~hit[0]} + {1'b0, ~hit[1]} + {1'b0, ~hit[2]};
      flush = ({1'b0, fill_base} + (FW+1)'(need)) > {1'b0, capacity_ff};

      // after a discard every corner is missing
      miss     = flush ? 3'b111 : ~hit;
      fresh[0] = miss[0];
      fresh[1] = miss[1] & (slot[1] != slot[0]);
      fresh[2] = miss[2] & (slot[2] != slot[0]) & (slot[2] != slot[1]);
      added    = {1'b0, fresh[0]} + {1'b0, fresh[1]} + {1'b0, fresh[2]};

      mark = (VERTEX_LIMIT'(1) << slot[0]) | (VERTEX_LIMIT'(1) << slot[1])
           | (VERTEX_LIMIT'(1) << slot[2]);
      in_window_in = (flush ? '0 : win_base) | mark;
      fill_in      = (flush ? '0 : fill_base) + FW'(added);

      // loaded plus fill never drops, so the cost follows by the new loads only
      cost_sum = {1'b0, cost_base} + (CW+1)'(added);
      cost_in  = cost_sum[CW] ? '1 : cost_sum[CW-1:0];

      rsp_next.flushed      = flush;
      rsp_next.new_vertices = added;
      rsp_next.window_fill  = fill_in;
      rsp_next.total_cost   = cost_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_window_ff <= '0;
         fill_ff      <= '0;
         cost_ff      <= '0;
      end else if (advance) begin
         in_window_ff <= in_window_in;
         fill_ff      <= fill_in;
         cost_ff      <= cost_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= vwlc_pkg::CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/vwlc_output_stage.sv -----
// ----------------------------------------------------------------------------
// vwlc_output_stage
// response register with stall hold
// ----------------------------------------------------------------------------
`default_nettype none

module vwlc_output_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire vwlc_pkg::rsp_type rsp_next,
   output      logic              out_ready,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      vwlc_pkg::rsp_type rsp_payload
);

   logic              valid_ff;
   logic              valid_in;
   vwlc_pkg::rsp_type payload_ff;

   assign out_ready   = ~valid_ff | ~rsp_stall;
   assign valid_in    = load | (valid_ff & rsp_stall);
   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= rsp_next;
      end
   end

endmodule

`default_nettype wire

// ----- src/vertex_window_load_cost.sv -----
// ----------------------------------------------------------------------------
// vertex_window_load_cost
// vertex window load cost per triangle
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one triangle per transaction (start_mesh, three corners).
//   rsp channel: one result per triangle (flushed, new_vertices,
//   window_fill, total_cost), in order.
//   csr port: csr_wr_en with csr_wr_data writes window_capacity; write only
//   while no transaction is in flight.
//   Path: an accepted request waits in the input register; its result is
//   loaded into the output register, which drives rsp_valid.
//   Throughput: 1 triangle per cycle while rsp_stall holds no pending result;
//   the membership bits live in a flop vector, so the three lookups, the
//   discard and the three marks of one triangle are all done in one update.
//   Reset: synchronous, active high; clears both channels, the membership
//   vector, fill and cost and sets window_capacity to 64.
//   Stall: while rsp_stall holds a pending result, at most one more request
//   is taken into the input register and then req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_window_load_cost #(
   parameter int VERTEX_LIMIT = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire vwlc_pkg::req_type           req_payload,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      vwlc_pkg::rsp_type           rsp_payload,
   input  wire logic                        csr_wr_en,
   input  wire logic [vwlc_pkg::FILL_W-1:0] csr_wr_data
);

   localparam int SLOT_W = $clog2(VERTEX_LIMIT);

   logic                   item_valid;
   logic                   out_ready;
   logic                   advance;
   logic                   start_mesh;
   logic [2:0][SLOT_W-1:0] slot;
   vwlc_pkg::rsp_type      rsp_next;

   assign advance = item_valid & out_ready;

   vwlc_input_stage #(
      .VERTEX_LIMIT (VERTEX_LIMIT),
      .SLOT_W       (SLOT_W)
   ) u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .advance     (advance),
      .item_valid  (item_valid),
      .start_mesh  (start_mesh),
      .slot        (slot)
   );

   vwlc_window_core #(
      .VERTEX_LIMIT (VERTEX_LIMIT),
      .SLOT_W       (SLOT_W)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .start_mesh  (start_mesh),
      .slot        (slot),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_next    (rsp_next)
   );

   vwlc_output_stage u_output (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .rsp_next    (rsp_next),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- src/vwlc_checker.sv -----
// ----------------------------------------------------------------------------
// vwlc_assertions
// port-level checks on the vertex window load cost block
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vwlc_assertions (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire vwlc_pkg::rsp_type rsp_payload
);

   // held result stays put
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // a discard leaves only this triangle's vertices in the window
   `ASSERT_IMPLIES(a_flush_fill, clock, reset, rsp_valid && rsp_payload.flushed, rsp_payload.window_fill <= 8'd3)

   // new loads are part of the fill
   `ASSERT_IMPLIES(a_new_in_fill, clock, reset, rsp_valid, {6'd0, rsp_payload.new_vertices} <= rsp_payload.window_fill)

   // cost covers the current fill
   `ASSERT_IMPLIES(a_cost_fill, clock, reset, rsp_valid, rsp_payload.total_cost >= {24'd0, rsp_payload.window_fill})

   // no back-pressure while the result side is empty
   `ASSERT_IMPLIES(a_no_idle_stall, clock, reset, !rsp_valid && req_valid, !req_stall)

endmodule

bind vertex_window_load_cost vwlc_assertions u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ----- sim/vwlc_checker.sv -----
// ----------------------------------------------------------------------------
// vwlc_checker
// result checker for the vertex window load cost block
// ----------------------------------------------------------------------------
// Watches the request, result and csr ports. Each accepted request runs
// through a local copy of the vertex window (membership bits, fill, loaded
// total, capacity) and its expected result is queued. Each accepted result
// is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vwlc_checker
   import vwlc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire req_type           req_payload,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire rsp_type           rsp_payload,
   input  wire logic              csr_wr_en,
   input  wire logic [FILL_W-1:0] csr_wr_data,
   output int                     fail_count,
   output int                     pending,
   output int                     flush_count
);

   localparam int VERTEX_SLOTS = 1024;

   logic [VERTEX_SLOTS-1:0] member_bits;
   logic [FILL_W-1:0]       fill_now;
   logic [FILL_W-1:0]       capacity_now;
   logic [COST_W-1:0]       loaded_before;
   rsp_type                 expected_costs [$];

   function automatic logic [COST_W-1:0] add_sat(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
      logic [COST_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COST_W] ? '1 : sum[COST_W-1:0];
   endfunction

   function automatic rsp_type cost_triangle(input req_type tri_in);
      logic [CORNER_W-1:0] slot [0:2];
      int                  need;
      int                  added;
      logic                flush;
      rsp_type             res;
      slot[0] = tri_in.corner_a;
      slot[1] = tri_in.corner_b;
      slot[2] = tri_in.corner_c;
      if (tri_in.start_mesh) begin
         member_bits   = '0;
         fill_now      = '0;
         loaded_before = '0;
      end
      need = 0;
      for (int k = 0; k < 3; k++) begin
         if (!member_bits[slot[k]]) need++;
      end
      flush = (int'(fill_now) + need) > int'(capacity_now);
      if (flush) begin
         loaded_before = add_sat(loaded_before, {{(COST_W-FILL_W){1'b0}}, fill_now});
         member_bits   = '0;
         fill_now      = '0;
      end
      added = 0;
      for (int k = 0; k < 3; k++) begin
         if (!member_bits[slot[k]]) begin
            member_bits[slot[k]] = 1'b1;
            added++;
         end
      end
      fill_now = fill_now + added[FILL_W-1:0];
      res.flushed      = flush;
      res.new_vertices = added[NEW_W-1:0];
      res.window_fill  = fill_now;
      res.total_cost   = add_sat(loaded_before, {{(COST_W-FILL_W){1'b0}}, fill_now});
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      logic    bad;
      if (reset) begin
         member_bits   = '0;
         fill_now      = '0;
         loaded_before = '0;
         capacity_now  = CAPACITY_RESET;
         expected_costs.delete();
         fail_count    = 0;
         flush_count   = 0;
      end else begin
         if (csr_wr_en) capacity_now = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_costs.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: flushed=%0d new=%0d fill=%0d cost=%0d",
                           rsp_payload.flushed, rsp_payload.new_vertices,
                           rsp_payload.window_fill, rsp_payload.total_cost);
            end else begin
               want = expected_costs.pop_front();
               bad  = (rsp_payload.flushed !== want.flushed) ||
                      (rsp_payload.new_vertices !== want.new_vertices) ||
                      (rsp_payload.window_fill !== want.window_fill) ||
                      (rsp_payload.total_cost !== want.total_cost);
               if (bad) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected flushed=%0d new=%0d fill=%0d cost=%0d, %s%0d %s%0d %s%0d %s%0d",
                              want.flushed, want.new_vertices, want.window_fill,
                              want.total_cost,
                              "got flushed=", rsp_payload.flushed,
                              "new=", rsp_payload.new_vertices,
                              "fill=", rsp_payload.window_fill,
                              "cost=", rsp_payload.total_cost);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = cost_triangle(req_payload);
            if (want.flushed) flush_count++;
            expected_costs.push_back(want);
         end
      end
      pending = expected_costs.size();
   end

endmodule

// ----- sim/tb_vertex_window_load_cost.sv -----
// ----------------------------------------------------------------------------
// tb_vertex_window_load_cost
// testbench for the vertex window load cost block
// ----------------------------------------------------------------------------
// Directed triangles at several capacities (repeated corners, empty-window
// discard, capacities below three, extreme indices), then random phases of
// mesh-local index streams with some noise, each under its own capacity.
// Both sides idle in random bursts; one long result hold-off backs the block
// up. The checker module predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vertex_window_load_cost;
   import vwlc_pkg::*;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_payload;
   logic              csr_wr_en;
   logic [FILL_W-1:0] csr_wr_data;

   int                fail_count;
   int                pending;
   int                flush_count;

   logic              idle_on;
   logic              pressure_go;
   logic              hold_done;
   int                triangles_sent;
   int                capacity_writes;
   logic [CORNER_W-1:0] mesh_base;
   int                mesh_span;

   vertex_window_load_cost u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   vwlc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .flush_count (flush_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: random stall bursts plus one long hold-off
   initial begin : receiver
      int len;
      rsp_stall = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_go && !hold_done) begin
            rsp_stall = 1'b1;
            hold_done = 1'b1;
            repeat (299) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, 17);
            rsp_stall = 1'b1;
            repeat (len - 1) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic feed_triangle(input req_type tri_in);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = tri_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      triangles_sent++;
      @(negedge clock);
   endtask

   task automatic send_corners(input logic sm, input logic [CORNER_W-1:0] a,
                               input logic [CORNER_W-1:0] b,
                               input logic [CORNER_W-1:0] c);
      req_type t;
      t.start_mesh = sm;
      t.corner_a   = a;
      t.corner_b   = b;
      t.corner_c   = c;
      feed_triangle(t);
   endtask

   task automatic settle_window();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [FILL_W-1:0] cap);
      csr_wr_en   = 1'b1;
      csr_wr_data = cap;
      @(negedge clock);
      csr_wr_en = 1'b0;
      capacity_writes++;
   endtask

   // mostly mesh-local index streams, some full-range noise
   function automatic req_type random_triangle();
      req_type t;
      int      kind;
      kind = $urandom_range(0, 19);
      t.start_mesh = ($urandom_range(0, 49) == 0);
      if (t.start_mesh) begin
         mesh_base = CORNER_W'($urandom_range(0, 1023));
         mesh_span = $urandom_range(2, 400);
      end
      if (kind == 0) mesh_base = mesh_base + CORNER_W'($urandom_range(1, 16));
      if (kind < 16) begin
         t.corner_a = mesh_base + CORNER_W'($urandom_range(0, mesh_span));
         t.corner_b = mesh_base + CORNER_W'($urandom_range(0, mesh_span));
         t.corner_c = mesh_base + CORNER_W'($urandom_range(0, mesh_span));
         if (kind >= 13) t.corner_c = t.corner_a;
         if (kind == 15) t.corner_b = t.corner_a;
      end else begin
         t.corner_a = CORNER_W'($urandom);
         t.corner_b = CORNER_W'($urandom);
         t.corner_c = CORNER_W'($urandom);
         if (kind == 19) t.start_mesh = 1'($urandom_range(0, 1));
      end
      return t;
   endfunction

   initial begin : stimulus
      logic [FILL_W-1:0] caps [0:6];
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_payload     = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      idle_on         = 1'b0;
      pressure_go     = 1'b0;
      triangles_sent  = 0;
      capacity_writes = 0;
      mesh_base       = '0;
      mesh_span       = 64;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset   = 1'b0;
      idle_on = 1'b1;

      // reset capacity
      send_corners(1'b1, 10'd0, 10'd1, 10'd2);
      send_corners(1'b0, 10'd0, 10'd1, 10'd2);
      send_corners(1'b0, 10'd1023, 10'd1023, 10'd1023);
      send_corners(1'b0, 10'd5, 10'd5, 10'd6);
      send_corners(1'b0, 10'd1023, 10'd0, 10'd7);
      send_corners(1'b0, 10'h155, 10'h2AA, 10'h3FF);
      send_corners(1'b1, 10'h2AA, 10'h155, 10'h000);
      settle_window();

      // capacity of three, exact fit then discard
      write_capacity(8'd3);
      send_corners(1'b1, 10'd0, 10'd1, 10'd2);
      send_corners(1'b0, 10'd2, 10'd1, 10'd0);
      send_corners(1'b0, 10'd0, 10'd1, 10'd3);
      send_corners(1'b0, 10'd3, 10'd3, 10'd3);
      send_corners(1'b0, 10'd4, 10'd4, 10'd5);
      settle_window();

      // zero capacity: discard of an empty window
      write_capacity(8'd0);
      send_corners(1'b1, 10'd0, 10'd0, 10'd0);
      send_corners(1'b0, 10'd0, 10'd0, 10'd0);
      send_corners(1'b0, 10'd1, 10'd2, 10'd3);
      settle_window();

      write_capacity(8'd1);
      send_corners(1'b1, 10'd8, 10'd9, 10'd8);
      send_corners(1'b0, 10'd8, 10'd8, 10'd8);
      send_corners(1'b0, 10'd9, 10'd9, 10'd9);
      settle_window();

      write_capacity(8'd2);
      send_corners(1'b1, 10'd20, 10'd21, 10'd22);
      send_corners(1'b0, 10'd20, 10'd21, 10'd20);
      settle_window();

      write_capacity(8'd255);
      send_corners(1'b1, 10'd1023, 10'd1022, 10'd1021);
      send_corners(1'b0, 10'd0, 10'd1, 10'd2);
      send_corners(1'b0, 10'd1021, 10'd2, 10'd1023);
      settle_window();

      caps[0] = 8'd255;
      caps[1] = 8'd3;
      caps[2] = FILL_W'($urandom_range(4, 254));
      caps[3] = FILL_W'($urandom_range(0, 2));
      caps[4] = 8'd64;
      caps[5] = FILL_W'($urandom_range(3, 255));
      caps[6] = 8'd255;
      for (int p = 0; p < 7; p++) begin
         write_capacity(caps[p]);
         if (p == 0) pressure_go = 1'b1;
         if (p == 6) idle_on = 1'b0;
         repeat (250) feed_triangle(random_triangle());
         settle_window();
      end

      repeat (8) @(negedge clock);
      $display("covered %0d triangles under %0d capacity writes, %0d window flushes",
               triangles_sent, capacity_writes, flush_count);
      $display("capacities from zero to 255, one long result hold-off, %0d failures",
               fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- vertex_window_load_cost.f -----
+incdir+src
src/vwlc_pkg.sv
src/vwlc_input_stage.sv
src/vwlc_window_core.sv
src/vwlc_output_stage.sv
src/vertex_window_load_cost.sv
src/vwlc_checker.sv
sim/vwlc_checker.sv
sim/tb_vertex_window_load_cost.sv
